FILE: hdl/psv_pkg.sv
// Shared types, constants and tables of the pulsating-sphere velocity block.
// Used by every module under hdl but psv_delay; depends on nothing.
`default_nettype none

package psv_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_N            = 24;

    // pi in Q2.30 with 32 bits, and the CORDIC gain compensation in Q2.30
    localparam logic [31:0]        PI_Q30   = 32'd3373259426;
    localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
    localparam logic signed [33:0] S_ONE    = 34'sh0_4000_0000;

    // register map, byte address 4*index
    typedef enum logic [2:0] {
        REG_WINDOW_START = 3'd0,
        REG_WINDOW_END   = 3'd1,
        REG_PULSE_AMP    = 3'd2,
        REG_PULSE_FREQ   = 3'd3,
        REG_CENTER_X     = 3'd4,
        REG_CENTER_Y     = 3'd5,
        REG_CENTER_Z     = 3'd6,
        REG_TIME_TOL     = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } cordic_state_t;

    typedef struct packed {
        logic [65:0] rad;
        logic [34:0] rem;
        logic [32:0] root;
    } sqrt_state_t;

    typedef struct packed {
        logic [32:0] rem;
        logic        pend;
        logic [30:0] quo;
    } div_lane_t;

    // truncated atan(2^-i) in Q2.30
    function automatic logic [31:0] atan_q30(input int unsigned idx);
        logic [31:0] a;
        case (idx)
            0:  a = 32'h3243F6A8;
            1:  a = 32'h1DAC6705;
            2:  a = 32'h0FADBAFC;
            3:  a = 32'h07F56EA6;
            4:  a = 32'h03FEAB76;
            5:  a = 32'h01FFD55B;
            6:  a = 32'h00FFFAAA;
            7:  a = 32'h007FFF55;
            8:  a = 32'h003FFFEA;
            9:  a = 32'h001FFFFD;
            10: a = 32'h000FFFFF;
            11: a = 32'h0007FFFF;
            12: a = 32'h0003FFFF;
            13: a = 32'h0001FFFF;
            14: a = 32'h0000FFFF;
            15: a = 32'h00007FFF;
            16: a = 32'h00003FFF;
            17: a = 32'h00001FFF;
            18: a = 32'h00000FFF;
            19: a = 32'h000007FF;
            20: a = 32'h000003FF;
            21: a = 32'h000001FF;
            22: a = 32'h000000FF;
            23: a = 32'h0000007F;
            default: a = 32'h0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/psv_delay.sv
// Enabled shift line that carries side data alongside the cell chains.
// Depends on nothing.
`default_nettype none

module psv_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] line_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[DEPTH-1];

endmodule

`default_nettype wire

FILE: hdl/psv_cordic_cell.sv
// One rotation-mode CORDIC step with its output register.
// Depends on psv_pkg for the state type and the atan table.
`default_nettype none

module psv_cordic_cell
    import psv_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire cordic_state_t st_in,
    output cordic_state_t      st_out
);

    cordic_state_t      st_reg;
    cordic_state_t      st_next;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] at;

    always_comb
    begin
        xs = st_in.x >>> IDX;
        ys = st_in.y >>> IDX;
        at = $signed({2'b00, atan_q30(IDX)});
        if (!st_in.z[33])
        begin
            st_next.x = st_in.x - ys;
            st_next.y = st_in.y + xs;
            st_next.z = st_in.z - at;
        end
        else
        begin
            st_next.x = st_in.x + ys;
            st_next.y = st_in.y - xs;
            st_next.z = st_in.z + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

`default_nettype wire

FILE: hdl/psv_sqrt_cell.sv
// One digit step of the restoring integer square root, registered.
// Depends on psv_pkg for the state type.
`default_nettype none

module psv_sqrt_cell
    import psv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire sqrt_state_t st_in,
    output sqrt_state_t      st_out
);

    sqrt_state_t st_reg;
    sqrt_state_t st_next;
    logic [36:0] rem_sh;
    logic [36:0] trial;

    always_comb
    begin
        rem_sh = {st_in.rem, st_in.rad[65:64]};
        trial  = {2'b00, st_in.root, 2'b01};
        st_next.rad = {st_in.rad[63:0], 2'b00};
        if (rem_sh >= trial)
        begin
            st_next.rem  = 35'(rem_sh - trial);
            st_next.root = {st_in.root[31:0], 1'b1};
        end
        else
        begin
            st_next.rem  = rem_sh[34:0];
            st_next.root = {st_in.root[31:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

`default_nettype wire

FILE: hdl/psv_div_cell.sv
// One quotient bit of the three-lane restoring divide by the radius, registered.
// Depends on psv_pkg for the lane type.
`default_nettype none

module psv_div_cell
    import psv_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic      [32:0]     dvs_in,
    input  wire div_lane_t [2:0]      lane_in,
    output logic           [32:0]     dvs_out,
    output div_lane_t      [2:0]      lane_out
);

    logic      [32:0] dvs_reg;
    div_lane_t [2:0]  lane_reg;
    div_lane_t [2:0]  lane_next;
    logic      [33:0] sh;

    always_comb
    begin
        sh = '0;
        for (int k = 0; k < 3; k++)
        begin
            sh = {lane_in[k].rem, lane_in[k].pend};
            lane_next[k].pend = 1'b0;
            if (sh >= {1'b0, dvs_in})
            begin
                lane_next[k].rem = 33'(sh - {1'b0, dvs_in});
                lane_next[k].quo = {lane_in[k].quo[29:0], 1'b1};
            end
            else
            begin
                lane_next[k].rem = sh[32:0];
                lane_next[k].quo = {lane_in[k].quo[29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvs_reg  <= dvs_in;
            lane_reg <= lane_next;
        end
    end

    assign dvs_out  = dvs_reg;
    assign lane_out = lane_reg;

endmodule

`default_nettype wire

FILE: hdl/pulsating_sphere_velocity.sv
// Top level of the pulsating-sphere velocity block: stream ports, register file,
// arithmetic stages and the cell chains. Depends on psv_pkg and all psv_* cells.
//
// Each request carries a time and a point; the block returns the point's radial
// velocity amplitude*2*pi*f*sin(2*pi*f*t)*d/|d| with d = point - center, in
// signed Q16.16 saturated to 32 bits, plus an in-window flag and a flag for a
// point at the center. A new request is taken every cycle while the pipeline
// is not held; each passes the chain of 33 square-root cells followed by 31
// divider cells that produce d/|d|, while the sine runs in a parallel CORDIC
// chain. The whole pipeline advances together: it holds only while a finished
// result sits in the output register and the sink does not take it. Registers
// are to be written over APB only while the block is idle (not enforced).
`default_nettype none

module pulsating_sphere_velocity
    import psv_pkg::*;
#(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // s_tdata: sample_time, pos_x, pos_y, pos_z (lowest bit up)
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,
    // m_tdata: vel_x, vel_y, vel_z (lowest bit up)
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,
    // m_tuser: in_window, at_center (lowest bit up)
    output logic [1:0]        m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int NC     = (CORDIC_STAGES < ATAN_N) ? CORDIC_STAGES : ATAN_N;
    localparam int AF_W   = 64 - FRAC_BITS;   // |A|*f after the fraction shift
    localparam int AFH_W  = AF_W - 32;
    localparam int PW_W   = AF_W + 32;
    localparam int WSH_W  = PW_W - 29;        // width of W and of M
    localparam int WH_W   = WSH_W - 32;
    localparam int U_LO   = 2 * FRAC_BITS;
    localparam int N_VLD  = 68;

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [31:0] window_start_reg;
    logic [31:0] window_end_reg;
    logic [31:0] pulse_amplitude_reg;
    logic [31:0] pulse_frequency_reg;
    logic [31:0] center_x_reg;
    logic [31:0] center_y_reg;
    logic [31:0] center_z_reg;
    logic [15:0] time_tolerance_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg    <= 32'h0;
            window_end_reg      <= 32'hFFFF_FFFF;
            pulse_amplitude_reg <= 32'h0;
            pulse_frequency_reg <= 32'h0;
            center_x_reg        <= 32'h0;
            center_y_reg        <= 32'h0;
            center_z_reg        <= 32'h0;
            time_tolerance_reg  <= 16'h1;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_WINDOW_START: window_start_reg    <= pwdata;
                REG_WINDOW_END:   window_end_reg      <= pwdata;
                REG_PULSE_AMP:    pulse_amplitude_reg <= pwdata;
                REG_PULSE_FREQ:   pulse_frequency_reg <= pwdata;
                REG_CENTER_X:     center_x_reg        <= pwdata;
                REG_CENTER_Y:     center_y_reg        <= pwdata;
                REG_CENTER_Z:     center_z_reg        <= pwdata;
                REG_TIME_TOL:     time_tolerance_reg  <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_WINDOW_START: prdata = window_start_reg;
            REG_WINDOW_END:   prdata = window_end_reg;
            REG_PULSE_AMP:    prdata = pulse_amplitude_reg;
            REG_PULSE_FREQ:   prdata = pulse_frequency_reg;
            REG_CENTER_X:     prdata = center_x_reg;
            REG_CENTER_Y:     prdata = center_y_reg;
            REG_CENTER_Z:     prdata = center_z_reg;
            REG_TIME_TOL:     prdata = {16'h0, time_tolerance_reg};
            default:          prdata = 32'h0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves unless the output register holds
    // a result that the sink does not take this cycle.
    // ------------------------------------------------------------------
    logic             en;
    logic [N_VLD:1]   vld_reg;
    logic             out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[N_VLD-1:1], s_tvalid};
            out_valid_reg <= vld_reg[N_VLD];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offsets, window test, phase product, |A|*f
    // ------------------------------------------------------------------
    logic [31:0]       t_in;
    logic [2:0][31:0]  pos_in;
    logic [2:0][31:0]  ctr;
    logic [2:0][32:0]  d_s1;
    logic [2:0][31:0]  md_s1;
    logic [2:0]        dneg_s1;
    logic              win_s1;
    logic [63:0]       ft_s1;
    logic [95:0]       ft_wide;
    logic [31:0]       amp_abs;
    logic [63:0]       af_full;

    logic [2:0][31:0]  md1_reg;
    logic [2:0]        dneg1_reg;
    logic              win1_reg;
    logic [31:0]       u1_reg;
    logic [AF_W-1:0]   af1_reg;
    logic              ampneg1_reg;

    assign t_in   = s_tdata[31:0];
    assign pos_in = s_tdata[127:32];
    assign ctr    = {center_z_reg, center_y_reg, center_x_reg};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_s1[k]    = {pos_in[k][31], pos_in[k]} - {ctr[k][31], ctr[k]};
            dneg_s1[k] = d_s1[k][32];
            md_s1[k]   = d_s1[k][32] ? 32'(-d_s1[k]) : d_s1[k][31:0];
        end
        // tolerant window, compared without wrap
        win_s1  = ({1'b0, t_in} + {17'h0, time_tolerance_reg} >= {1'b0, window_start_reg})
                  && ({1'b0, t_in} <= {1'b0, window_end_reg} + {17'h0, time_tolerance_reg});
        ft_s1   = 64'(pulse_frequency_reg) * 64'(t_in);
        ft_wide = {ft_s1, 32'h0};
        amp_abs = pulse_amplitude_reg[31] ? 32'(-pulse_amplitude_reg) : pulse_amplitude_reg;
        af_full = 64'(amp_abs) * 64'(pulse_frequency_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            md1_reg     <= md_s1;
            dneg1_reg   <= dneg_s1;
            win1_reg    <= win_s1;
            u1_reg      <= ft_wide[U_LO+31:U_LO];   // turn fraction as Q0.32
            af1_reg     <= af_full[63:FRAC_BITS];
            ampneg1_reg <= pulse_amplitude_reg[31];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares, angle in radians, partial products of W
    // ------------------------------------------------------------------
    logic [2:0][63:0]     sq2_reg;
    logic [30:0]          theta2_reg;
    logic [1:0]           quad2_reg;
    logic [63:0]          pwlo2_reg;
    logic [AFH_W+31:0]    pwhi2_reg;
    logic [61:0]          th_prod;

    assign th_prod = 62'(u1_reg[29:0]) * 62'(PI_Q30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq2_reg[k] <= 64'(md1_reg[k]) * 64'(md1_reg[k]);
            end
            theta2_reg <= th_prod[61:31];
            quad2_reg  <= u1_reg[31:30];
            pwlo2_reg  <= 64'(af1_reg[31:0]) * 64'(PI_Q30);
            pwhi2_reg  <= (AFH_W+32)'(af1_reg[AF_W-1:32]) * (AFH_W+32)'(PI_Q30);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum of squares and W = floor(P*pi_q30 / 2^29).
    // W stays below 2^(67-FRAC_BITS), so it fits in WSH_W bits.
    // ------------------------------------------------------------------
    logic [65:0]        sum3_reg;
    logic [WSH_W-1:0]   w3_reg;
    logic [PW_W-1:0]    w_prod;

    assign w_prod = (PW_W'(pwhi2_reg) << 32) + PW_W'(pwlo2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum3_reg <= 66'(sq2_reg[0]) + 66'(sq2_reg[1]) + 66'(sq2_reg[2]);
            w3_reg   <= w_prod[PW_W-1:29];
        end
    end

    // ------------------------------------------------------------------
    // CORDIC chain: stages 3 .. NC+2
    // ------------------------------------------------------------------
    cordic_state_t cs [NC+1];

    assign cs[0].x = CORDIC_K;
    assign cs[0].y = '0;
    assign cs[0].z = $signed({3'b000, theta2_reg});

    for (genvar i = 0; i < NC; i++)
    begin : g_cordic
        psv_cordic_cell #(
            .IDX (i)
        ) u_cell (
            .clk    (clk),
            .en     (en),
            .st_in  (cs[i]),
            .st_out (cs[i+1])
        );
    end

    logic [1:0]       quad_d;
    logic [WSH_W-1:0] w_d;

    psv_delay #(.WIDTH(2), .DEPTH(NC)) u_quad_dly (
        .clk (clk), .en (en), .din (quad2_reg), .dout (quad_d)
    );

    // W leaves stage 3, one stage after the angle; line it up with the sine
    psv_delay #(.WIDTH(WSH_W), .DEPTH(NC-1)) u_w_dly (
        .clk (clk), .en (en), .din (w3_reg), .dout (w_d)
    );

    // Stage NC+3: fold the quadrant back in and clip to +-1.0
    logic signed [33:0] s_sel;
    logic signed [33:0] s_clip;
    logic [30:0]        sabs_reg;
    logic               sneg_reg;
    logic [WSH_W-1:0]   w_s_reg;

    always_comb
    begin
        case (quad_t'(quad_d))
            QUAD_0:  s_sel = cs[NC].y;
            QUAD_1:  s_sel = cs[NC].x;
            QUAD_2:  s_sel = -cs[NC].y;
            QUAD_3:  s_sel = -cs[NC].x;
            default: s_sel = cs[NC].y;
        endcase
        if (s_sel > S_ONE)
        begin
            s_clip = S_ONE;
        end
        else if (s_sel < -S_ONE)
        begin
            s_clip = -S_ONE;
        end
        else
        begin
            s_clip = s_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sabs_reg <= s_clip[33] ? 31'(-s_clip) : s_clip[30:0];
            sneg_reg <= s_clip[33];
            w_s_reg  <= w_d;
        end
    end

    // Stage NC+4: partial products of M = W*|sin| / 2^30
    logic [62:0]      pmlo_reg;
    logic [WH_W+30:0] pmhi_reg;
    logic             sneg4_reg;
    logic             ampneg_d;

    psv_delay #(.WIDTH(1), .DEPTH(NC+3)) u_amp_dly (
        .clk (clk), .en (en), .din (ampneg1_reg), .dout (ampneg_d)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pmlo_reg  <= 63'(w_s_reg[31:0]) * 63'(sabs_reg);
            pmhi_reg  <= (WH_W+31)'(w_s_reg[WSH_W-1:32]) * (WH_W+31)'(sabs_reg);
            sneg4_reg <= sneg_reg;
        end
    end

    // Stage NC+5: M and the sign common to all three axes
    logic [WSH_W+30:0] m_prod;
    logic [WSH_W-1:0]  m5_reg;
    logic              nbase5_reg;

    assign m_prod = ((WSH_W+31)'(pmhi_reg) << 32) + (WSH_W+31)'(pmlo_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m5_reg     <= m_prod[WSH_W+29:30];
            nbase5_reg <= ampneg_d ^ sneg4_reg;
        end
    end

    logic [WSH_W:0] mb_d;

    psv_delay #(.WIDTH(WSH_W+1), .DEPTH(62-NC)) u_m_dly (
        .clk (clk), .en (en), .din ({nbase5_reg, m5_reg}), .dout (mb_d)
    );

    // ------------------------------------------------------------------
    // Square-root chain: stages 4 .. 36
    // ------------------------------------------------------------------
    sqrt_state_t ss [34];

    assign ss[0].rad  = sum3_reg;
    assign ss[0].rem  = '0;
    assign ss[0].root = '0;

    for (genvar i = 0; i < 33; i++)
    begin : g_sqrt
        psv_sqrt_cell u_cell (
            .clk    (clk),
            .en     (en),
            .st_in  (ss[i]),
            .st_out (ss[i+1])
        );
    end

    logic [2:0][31:0] md_d;

    psv_delay #(.WIDTH(96), .DEPTH(35)) u_md_dly (
        .clk (clk), .en (en), .din (md1_reg), .dout (md_d)
    );

    // ------------------------------------------------------------------
    // Divider chain: q = floor(|d|*2^30 / r), stages 37 .. 67
    // ------------------------------------------------------------------
    logic      [32:0]    dvs [32];
    div_lane_t [2:0]     lanes [32];

    assign dvs[0] = ss[33].root;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            // start from |d|*2^30 / 2^31; the dropped low bit enters first
            lanes[0][k].rem  = {2'b00, md_d[k][31:1]};
            lanes[0][k].pend = md_d[k][0];
            lanes[0][k].quo  = '0;
        end
    end

    for (genvar j = 0; j < 31; j++)
    begin : g_div
        psv_div_cell u_cell (
            .clk      (clk),
            .en       (en),
            .dvs_in   (dvs[j]),
            .lane_in  (lanes[j]),
            .dvs_out  (dvs[j+1]),
            .lane_out (lanes[j+1])
        );
    end

    logic       zero_d;
    logic [3:0] fl_d;

    psv_delay #(.WIDTH(1), .DEPTH(31)) u_zero_dly (
        .clk (clk), .en (en), .din (ss[33].root == 33'h0), .dout (zero_d)
    );

    psv_delay #(.WIDTH(4), .DEPTH(66)) u_flag_dly (
        .clk (clk), .en (en), .din ({dneg1_reg, win1_reg}), .dout (fl_d)
    );

    // ------------------------------------------------------------------
    // Stage 68: partial products of |vel| = M*q / 2^30
    // ------------------------------------------------------------------
    logic [2:0][62:0]      pvlo_reg;
    logic [2:0][WH_W+30:0] pvhi_reg;
    logic [2:0]            dneg68_reg;
    logic                  win68_reg;
    logic                  zero68_reg;
    logic                  nbase68_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                pvlo_reg[k] <= 63'(mb_d[31:0]) * 63'(lanes[31][k].quo);
                pvhi_reg[k] <= (WH_W+31)'(mb_d[WSH_W-1:32]) * (WH_W+31)'(lanes[31][k].quo);
            end
            dneg68_reg  <= fl_d[3:1];
            win68_reg   <= fl_d[0];
            zero68_reg  <= zero_d;
            nbase68_reg <= mb_d[WSH_W];
        end
    end

    // ------------------------------------------------------------------
    // Stage 69: sign, saturate, force zero outside the window or at center
    // ------------------------------------------------------------------
    logic [2:0][31:0]  vel_next;
    logic [WSH_W+30:0] v_prod;
    logic [WSH_W-1:0]  vm;
    logic [2:0][31:0]  vel_reg;
    logic              win_o_reg;
    logic              ctr_o_reg;

    always_comb
    begin
        v_prod = '0;
        vm     = '0;
        for (int k = 0; k < 3; k++)
        begin
            v_prod = ((WSH_W+31)'(pvhi_reg[k]) << 32) + (WSH_W+31)'(pvlo_reg[k]);
            vm     = v_prod[WSH_W+29:30];
            if (!win68_reg || zero68_reg)
            begin
                vel_next[k] = 32'h0;
            end
            else if (nbase68_reg != dneg68_reg[k])
            begin
                vel_next[k] = (vm > WSH_W'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-vm);
            end
            else
            begin
                vel_next[k] = (vm > WSH_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : vm[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vel_reg   <= vel_next;
            win_o_reg <= win68_reg;
            ctr_o_reg <= win68_reg & zero68_reg;
        end
    end

    assign m_tdata = vel_reg;
    assign m_tuser = {ctr_o_reg, win_o_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_center_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("center flag raised outside the window");

    a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 96'h0)
        else $error("nonzero velocity outside the window");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while pipeline is held");

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking bench for pulsating_sphere_velocity: APB register setup, stream requests,
// an in-bench fixed-point velocity predictor and a result checker. Depends on psv_pkg.
`default_nettype none

module tb_top;
    import psv_pkg::*;

    localparam int FB        = 16;
    localparam int STAGES    = 16;
    localparam int LATENCY   = 69;
    localparam int WDOG_MAX  = 20000;
    localparam logic [63:0] LIM62 = 64'h4000_0000_0000_0000;

    typedef struct packed {
        logic signed [31:0] vz;
        logic signed [31:0] vy;
        logic signed [31:0] vx;
        logic               at_center;
        logic               in_window;
    } velocity_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // shadow copy of the register file
    logic [31:0] win_start, win_end, amp_reg, freq_reg, cx, cy, cz;
    logic [15:0] tol_reg;

    velocity_t expected_vel[$];
    int        errors;
    int        idle_cycles;
    bit        hold_sink;
    bit        sink_busy;

    pulsating_sphere_velocity dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    // floor(a*b / 2^sh), saturating at 2^62
    function automatic logic [63:0] mul_shr_sat(input logic [63:0] a, input logic [63:0] b,
                                               input int sh);
        logic [127:0] p;
        p = (128'(a) * 128'(b)) >> sh;
        return (p > 128'(LIM62)) ? LIM62 : p[63:0];
    endfunction

    function automatic logic [63:0] sqrt_floor(input logic [65:0] v);
        logic [67:0] rem;
        logic [67:0] root;
        logic [67:0] trial;
        rem  = '0;
        root = '0;
        for (int i = 32; i >= 0; i--)
        begin
            rem   = (rem << 2) | 68'(v[2*i +: 2]);
            trial = (root << 2) | 68'd1;
            if (rem >= trial)
            begin
                rem  = rem - trial;
                root = (root << 1) | 68'd1;
            end
            else
                root = root << 1;
        end
        return root[63:0];
    endfunction

    function automatic logic signed [63:0] asr64(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    // sine of a Q0.32 turn fraction in Q2.30
    function automatic logic signed [63:0] sine_of_turn(input logic [31:0] u);
        quad_t quad;
        logic signed [63:0] z, x, y, nx, s;
        quad = quad_t'(u[31:30]);
        z = 64'(({34'd0, u[29:0]} * 64'(PI_Q30)) >> 31);
        x = 64'(CORDIC_K);
        y = '0;
        for (int i = 0; i < STAGES && i < ATAN_N; i++)
        begin
            if (z >= 0)
            begin
                nx = x - asr64(y, i);
                y  = y + asr64(x, i);
                z  = z - 64'(atan_q30(i));
            end
            else
            begin
                nx = x + asr64(y, i);
                y  = y - asr64(x, i);
                z  = z + 64'(atan_q30(i));
            end
            x = nx;
        end
        case (quad)
            QUAD_0:  s = y;
            QUAD_1:  s = x;
            QUAD_2:  s = -y;
            default: s = -x;
        endcase
        if (s > 64'sd1073741824)  s = 64'sd1073741824;
        if (s < -64'sd1073741824) s = -64'sd1073741824;
        return s;
    endfunction

    function automatic velocity_t predict_velocity(input logic [127:0] req);
        velocity_t          res;
        logic [31:0]        t;
        logic signed [63:0] d[3];
        logic [63:0]        md[3];
        logic [65:0]        sumsq;
        logic [63:0]        r, ft, af, w, m, sm, q, vm;
        logic signed [63:0] s, amp, v;
        logic               neg_base;
        t     = req[31:0];
        d[0]  = 64'($signed(req[63:32]))  - 64'($signed(cx));
        d[1]  = 64'($signed(req[95:64]))  - 64'($signed(cy));
        d[2]  = 64'($signed(req[127:96])) - 64'($signed(cz));
        res   = '0;
        if (!(33'(t) + 33'(tol_reg) >= 33'(win_start) &&
              33'(t) <= 33'(win_end) + 33'(tol_reg)))
            return res;
        res.in_window = 1'b1;
        sumsq = '0;
        for (int k = 0; k < 3; k++)
        begin
            md[k] = d[k] < 0 ? 64'(-d[k]) : 64'(d[k]);
            sumsq = sumsq + 66'(md[k]) * 66'(md[k]);
        end
        r = sqrt_floor(sumsq);
        if (r == 0)
        begin
            res.at_center = 1'b1;
            return res;
        end
        ft  = 64'(freq_reg) * 64'(t);
        s   = sine_of_turn(ft[31:0]);
        amp = 64'($signed(amp_reg));
        af  = ((amp < 0) ? 64'(-amp) : 64'(amp)) * 64'(freq_reg);
        af  = af >> FB;
        w   = mul_shr_sat(af, 64'(PI_Q30), 29);
        sm  = s < 0 ? 64'(-s) : 64'(s);
        m   = mul_shr_sat(w, sm, 30);
        neg_base = (amp < 0) != (s < 0);
        for (int k = 0; k < 3; k++)
        begin
            q  = (md[k] << 30) / r;
            vm = mul_shr_sat(m, q, 30);
            if (neg_base != (d[k] < 0))
                v = (vm > 64'h8000_0000) ? -64'sh8000_0000 : -$signed(vm);
            else
                v = (vm > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : $signed(vm);
            case (k)
                0:       res.vx = v[31:0];
                1:       res.vy = v[31:0];
                default: res.vz = v[31:0];
            endcase
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- drivers

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 2;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WINDOW_START: win_start = value;
            REG_WINDOW_END:   win_end   = value;
            REG_PULSE_AMP:    amp_reg   = value;
            REG_PULSE_FREQ:   freq_reg  = value;
            REG_CENTER_X:     cx        = value;
            REG_CENTER_Y:     cy        = value;
            REG_CENTER_Z:     cz        = value;
            default:          tol_reg   = value[15:0];
        endcase
    endtask

    task automatic set_all(input logic [31:0] ws, input logic [31:0] we,
                           input logic [31:0] a, input logic [31:0] f,
                           input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input logic [15:0] tl);
        apb_write(REG_WINDOW_START, ws);
        apb_write(REG_WINDOW_END, we);
        apb_write(REG_PULSE_AMP, a);
        apb_write(REG_PULSE_FREQ, f);
        apb_write(REG_CENTER_X, x);
        apb_write(REG_CENTER_Y, y);
        apb_write(REG_CENTER_Z, z);
        apb_write(REG_TIME_TOL, {16'd0, tl});
    endtask

    // drain every outstanding result, then let the pipeline settle
    task automatic wait_idle();
        while (expected_vel.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // offer one request after an optional gap; hold until accepted
    task automatic send_request(input logic [31:0] t, input logic [31:0] x,
                                input logic [31:0] y, input logic [31:0] z,
                                input bit allow_gap);
        int gap;
        gap = 0;
        if (allow_gap)
        begin
            if ($urandom_range(99) < 5)
                gap = $urandom_range(40, 10);
            else if ($urandom_range(99) < 30)
                gap = $urandom_range(3, 1);
        end
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {z, y, x, t};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_vel.push_back(predict_velocity({z, y, x, t}));
        @(negedge clk);
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return 32'($signed($urandom_range(2000)) - 1000) << 16;
            2:       return 32'($signed($urandom_range(64)) - 32);
            default: return $urandom() >>> $urandom_range(24);
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    task automatic test_reset_values();
        // defaults: zero amplitude, full window; velocity is zero, flags vary
        send_request(32'd0, 32'd0, 32'd0, 32'd0, 0);
        send_request(32'hFFFF_FFFF, 32'h0001_0000, 32'd0, 32'd0, 0);
        end_burst();
        wait_idle();
    endtask

    task automatic test_directed_extremes();
        set_all(32'h0001_0000, 32'h0010_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                32'd0, 32'd0, 32'd0, 16'hFFFF);
        // window edges with the widest tolerance
        send_request(32'h0000_0001, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000, 0);
        send_request(32'h0000_0000, 32'h0001_0000, 32'd0, 32'd0, 0);
        send_request(32'h0010_FFFF, 32'h0001_0000, 32'd0, 32'd0, 0);
        send_request(32'h0011_0000, 32'h0001_0000, 32'd0, 32'd0, 0);
        // point at the center, and coordinate extremes
        send_request(32'h0002_0000, 32'd0, 32'd0, 32'd0, 0);
        send_request(32'h0002_4000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_request(32'h0002_8000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_request(32'h0003_1234, 32'h0000_0001, 32'hFFFF_FFFF, 32'd0, 0);
        end_burst();
        wait_idle();
        // negative amplitude, far center, each quadrant of the phase
        set_all(32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_4000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 16'd0);
        for (int i = 0; i < 8; i++)
            send_request(32'(i) << 15, 32'h8000_0000, 32'h7FFF_FFFF, 32'hEDCB_A988, 0);
        send_request(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0);
        end_burst();
        wait_idle();
        // empty window: start above end with no tolerance
        set_all(32'hFFFF_FFFF, 32'd0, 32'h0001_0000, 32'h0001_0000,
                32'd0, 32'd0, 32'd0, 16'd0);
        send_request(32'h8000_0000, 32'h0001_0000, 32'd0, 32'd0, 0);
        send_request(32'hFFFF_FFFF, 32'h0001_0000, 32'd0, 32'd0, 0);
        send_request(32'd0, 32'h0001_0000, 32'd0, 32'd0, 0);
        end_burst();
        wait_idle();
    endtask

    task automatic test_random_phases(input int phases, input int per_phase);
        logic [31:0] ws, we;
        for (int p = 0; p < phases; p++)
        begin
            ws = ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(32'h0004_0000));
            we = ($urandom_range(3) == 0) ? $urandom() : ws + 32'($urandom_range(32'h0100_0000));
            set_all(ws, we,
                    ($urandom_range(4) == 0) ? $urandom() : 32'($signed($urandom_range(
                        32'h0008_0000)) - 32'sh0004_0000),
                    ($urandom_range(4) == 0) ? $urandom() : 32'($urandom_range(32'h0004_0000)),
                    rand_coord(), rand_coord(), rand_coord(),
                    16'($urandom_range(16'hFFFF)));
            for (int i = 0; i < per_phase; i++)
            begin
                // mostly times inside the window so the arithmetic path is exercised
                if ($urandom_range(9) < 8 && we >= ws)
                    send_request(ws + 32'($urandom_range(we - ws)), rand_coord(),
                                 rand_coord(), rand_coord(), 1);
                else
                    send_request($urandom(), rand_coord(), rand_coord(), rand_coord(), 1);
            end
            end_burst();
            wait_idle();
        end
    endtask

    task automatic test_backpressure();
        // sink holds off while the sender keeps offering, filling the pipeline
        hold_sink = 1'b1;
        for (int i = 0; i < 150; i++)
            send_request($urandom(), rand_coord(), rand_coord(), rand_coord(), 0);
        end_burst();
        wait_idle();
    endtask

    // ---------------------------------------------------------------- sink

    // receiver: random stalls, plus one long hold-off when requested
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_sink && !sink_busy)
        begin
            sink_busy = 1'b1;
            m_tready <= 1'b0;
            repeat (300) @(negedge clk);
            hold_sink = 1'b0;
            sink_busy = 1'b0;
            m_tready <= 1'b1;
        end
        else if ($urandom_range(99) < 3)
            m_tready <= 1'b0;
        else if ($urandom_range(99) < 20)
            m_tready <= ~m_tready;
        else
            m_tready <= 1'b1;
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        velocity_t got;
        velocity_t want;
        if (rst_n && s_tvalid && s_tready || rst_n && m_tvalid && m_tready)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata, m_tuser[1], m_tuser[0]};
            if (expected_vel.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_vel.pop_front();
                if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
                    got.in_window !== want.in_window || got.at_center !== want.at_center)
                begin
                    $display("%0t: mismatch expected vx=%h vy=%h vz=%h win=%b ctr=%b",
                             $time, want.vx, want.vy, want.vz, want.in_window, want.at_center);
                    $display("%0t:          actual   vx=%h vy=%h vz=%h win=%b ctr=%b",
                             $time, got.vx, got.vy, got.vz, got.in_window, got.at_center);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("pulsating_sphere_velocity test failed");
            $finish;
        end
    end

    initial
    begin
        errors      = 0;
        idle_cycles = 0;
        hold_sink   = 1'b0;
        sink_busy   = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        win_start   = 32'd0;
        win_end     = 32'hFFFF_FFFF;
        amp_reg     = 32'd0;
        freq_reg    = 32'd0;
        cx          = 32'd0;
        cy          = 32'd0;
        cz          = 32'd0;
        tol_reg     = 16'd1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_directed_extremes();
        test_backpressure();
        test_random_phases(10, 95);

        wait_idle();
        if (errors == 0)
            $display("pulsating_sphere_velocity test passed");
        else
            $display("pulsating_sphere_velocity test failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: pulsating_sphere_velocity.f
hdl/psv_pkg.sv
hdl/psv_delay.sv
hdl/psv_cordic_cell.sv
hdl/psv_sqrt_cell.sv
hdl/psv_div_cell.sv
hdl/pulsating_sphere_velocity.sv
sim/tb_top.sv
